@@ hdl/bpa_pkg.sv @@
// Shared constants, types and elaboration-time tables for the buddy page allocator.
// No dependencies; used by bpa_map, buddy_page_allocator and the testbench.
package bpa_pkg;

    // Allocator geometry
    localparam int ORDERS      = 10;
    localparam int TOTAL_PAGES = 512;

    // Field widths
    localparam int PAGE_W   = 27;
    localparam int ORD_W    = 4;
    localparam int ORDN_W   = ORD_W + 1;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int REGION_W = 10;
    localparam int CFG_IDX_W = 1;

    // Page counts and block indexes up to TOTAL_PAGES
    localparam int NP_W = $clog2(TOTAL_PAGES + 1);

    // Bitmap words
    localparam int WORD_BITS = 32;
    localparam int SEL_W     = $clog2(WORD_BITS);

    // Commands
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'd1;

    // Bitmap words used by one order
    function automatic int words_at(input int k);
        int bits;
        int w;
        bits = TOTAL_PAGES >> k;
        w    = (bits + WORD_BITS - 1) >> SEL_W;
        return (w < 1) ? 1 : w;
    endfunction

    function automatic int calc_map_words();
        int sum;
        sum = 0;
        for (int k = 0; k < ORDERS; k++)
        begin
            sum += words_at(k);
        end
        return sum;
    endfunction

    localparam int MAP_WORDS = calc_map_words();
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    typedef logic [ADDR_W-1:0] word_tab_t [ORDERS];

    // First word of each order
    function automatic word_tab_t calc_word_off();
        word_tab_t tab;
        int acc;
        acc = 0;
        for (int k = 0; k < ORDERS; k++)
        begin
            tab[k] = ADDR_W'(acc);
            acc += words_at(k);
        end
        return tab;
    endfunction

    // Last word index within each order
    function automatic word_tab_t calc_last_word();
        word_tab_t tab;
        for (int k = 0; k < ORDERS; k++)
        begin
            tab[k] = ADDR_W'(words_at(k) - 1);
        end
        return tab;
    endfunction

    localparam word_tab_t WORD_OFF  = calc_word_off();
    localparam word_tab_t LAST_WORD = calc_last_word();

    // Bitmap memory request
    typedef struct packed {
        logic                 clr;
        logic                 rd;
        logic                 wr;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] wdata;
    } map_req_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CARVE,
        S_BIT_WR,
        S_ALLOC_EV,
        S_SPLIT,
        S_REL_CHK,
        S_REL_RD,
        S_REL_EV,
        S_FIN,
        S_DONE
    } state_t;

endpackage

@@ hdl/bpa_map.sv @@
// Free bitmap store: one word memory holding all orders, with per-row valid bits.
// Depends on bpa_pkg.
module bpa_map
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::map_req_t             req,
    output logic [bpa_pkg::WORD_BITS-1:0] rdata
);

    logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::MAP_WORDS];
    logic [bpa_pkg::MAP_WORDS-1:0] row_valid_reg;
    logic [bpa_pkg::WORD_BITS-1:0] rdata_reg;
    logic                          rvalid_reg;

    // Word storage, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    // Row valid bits; a row not written since reset or the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                row_valid_reg <= '0;
            end
            else if (req.wr)
            begin
                row_valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd)
            begin
                rvalid_reg <= row_valid_reg[req.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ hdl/buddy_page_allocator.sv @@
// Buddy page allocator top level: handshakes, configuration registers and sequencer.
// Depends on bpa_pkg and bpa_map.
//
// The free bitmaps of all orders sit in one 32-bit-word memory (36 words), and a small
// sequencer visits it one read or one write per cycle; the block takes one command at
// a time and in_ready is low while it works. Initialize carves the region into aligned
// blocks; no clearing pass is needed, since row valid bits are cleared at once. Allocate
// scans bitmap words in turn (up to 36, starting at the requested order), then splits
// the found block down level by level. Release checks the request, then merges with
// free buddies one order at a time.
// A finished result waits in the output register while the next command is accepted.
module buddy_page_allocator
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpa_pkg::PAGE_W-1:0]       cfg_data,
    // command channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bpa_pkg::CMD_W-1:0]        command,
    input  logic [bpa_pkg::ORD_W-1:0]        order,
    input  logic [bpa_pkg::PAGE_W-1:0]       page,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bpa_pkg::STAT_W-1:0]       status,
    output logic [bpa_pkg::PAGE_W-1:0]       block_page,
    output logic [bpa_pkg::ORD_W-1:0]        block_order
);

    bpa_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [bpa_pkg::PAGE_W-1:0]    base_page_reg;
    logic [bpa_pkg::REGION_W-1:0]  region_pages_reg;

    logic [bpa_pkg::ORD_W-1:0]     ord_reg, ord_next;
    logic [bpa_pkg::ORD_W-1:0]     k_reg, k_next;
    logic [bpa_pkg::NP_W-1:0]      idx_reg, idx_next;
    logic [bpa_pkg::ADDR_W-1:0]    w_reg, w_next;
    logic [bpa_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [bpa_pkg::SEL_W-1:0]     sel_reg, sel_next;
    logic [bpa_pkg::NP_W-1:0]      cur_reg, cur_next;
    logic [bpa_pkg::NP_W-1:0]      rem_reg, rem_next;
    logic [bpa_pkg::PAGE_W-1:0]    rel_reg, rel_next;
    logic                          ge_reg, ge_next;

    logic [bpa_pkg::STAT_W-1:0]    res_status_reg, res_status_next;
    logic [bpa_pkg::PAGE_W-1:0]    res_page_reg, res_page_next;
    logic [bpa_pkg::ORD_W-1:0]     res_ord_reg, res_ord_next;

    logic                          out_valid_reg;
    logic [bpa_pkg::STAT_W-1:0]    out_status_reg;
    logic [bpa_pkg::PAGE_W-1:0]    out_page_reg;
    logic [bpa_pkg::ORD_W-1:0]     out_ord_reg;

    bpa_pkg::map_req_t             map_req;
    logic [bpa_pkg::WORD_BITS-1:0] map_rdata;

    logic                          in_fire;
    logic                          out_free;
    logic                          order_ok;
    logic                          k_can_rise;
    logic                          more_words;
    logic                          rel_ok;
    logic                          word_found;
    logic [bpa_pkg::SEL_W-1:0]     first_sel;
    logic [bpa_pkg::ORD_W-1:0]     carve_k;
    logic [bpa_pkg::NP_W-1:0]      n_pages;
    logic [bpa_pkg::NP_W-1:0]      carve_idx;
    logic [bpa_pkg::NP_W-1:0]      split_idx;
    logic [bpa_pkg::NP_W-1:0]      split_tgt;
    logic [bpa_pkg::PAGE_W-1:0]    rel_size;
    logic [bpa_pkg::PAGE_W-1:0]    lim_ext;
    logic [bpa_pkg::PAGE_W-1:0]    fin_page;
    logic [bpa_pkg::SEL_W-1:0]     buddy_sel;

    bpa_map u_map
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rdata (map_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg    <= '0;
            region_pages_reg <= bpa_pkg::REGION_W'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpa_pkg::CFG_BASE_PAGE:    base_page_reg    <= cfg_data;
                bpa_pkg::CFG_REGION_PAGES: region_pages_reg <= cfg_data[bpa_pkg::REGION_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake status
    assign in_ready = (state_reg == bpa_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Shared conditions
    always_comb
    begin
        n_pages = (32'(region_pages_reg) < bpa_pkg::TOTAL_PAGES)
                  ? bpa_pkg::NP_W'(region_pages_reg) : bpa_pkg::NP_W'(bpa_pkg::TOTAL_PAGES);
        order_ok   = {1'b0, order} < bpa_pkg::ORDN_W'(bpa_pkg::ORDERS);
        k_can_rise = ({1'b0, k_reg} + bpa_pkg::ORDN_W'(1)) < bpa_pkg::ORDN_W'(bpa_pkg::ORDERS);
        more_words = w_reg < bpa_pkg::LAST_WORD[k_reg];
        rel_size   = bpa_pkg::PAGE_W'(1) << ord_reg;
        lim_ext    = bpa_pkg::PAGE_W'(n_pages);
        rel_ok     = ge_reg && (rel_reg < lim_ext) && (rel_size <= (lim_ext - rel_reg))
                     && ((rel_reg & (rel_size - bpa_pkg::PAGE_W'(1))) == '0);
        fin_page   = base_page_reg + (bpa_pkg::PAGE_W'(idx_reg) << k_reg);
        split_idx  = idx_reg << 1;
        split_tgt  = split_idx | bpa_pkg::NP_W'(1);
        buddy_sel  = {sel_reg[bpa_pkg::SEL_W-1:1], ~sel_reg[0]};
    end

    // Lowest set bit of the word just read
    always_comb
    begin
        word_found = |map_rdata;
        first_sel  = '0;
        for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (map_rdata[i])
            begin
                first_sel = bpa_pkg::SEL_W'(i);
            end
        end
    end

    // Largest aligned block that fits the remaining carve
    always_comb
    begin
        carve_k = '0;
        for (int i = 0; i < bpa_pkg::ORDERS; i++)
        begin
            if ((32'(1) << i) <= 32'(rem_reg)
                && (32'(cur_reg) & ((32'(1) << i) - 32'(1))) == 32'(0))
            begin
                carve_k = bpa_pkg::ORD_W'(i);
            end
        end
        carve_idx = cur_reg >> carve_k;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (command == bpa_pkg::CMD_INIT)
                        state_next = bpa_pkg::S_CARVE;
                    else if (command == bpa_pkg::CMD_ALLOC && order_ok)
                        state_next = bpa_pkg::S_ALLOC_EV;
                    else if (command == bpa_pkg::CMD_RELEASE && order_ok)
                        state_next = bpa_pkg::S_REL_CHK;
                    else
                        state_next = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_CARVE:
                state_next = (rem_reg == '0) ? bpa_pkg::S_DONE : bpa_pkg::S_BIT_WR;
            bpa_pkg::S_BIT_WR:
                state_next = ret_reg;
            bpa_pkg::S_ALLOC_EV:
            begin
                priority if (word_found)
                    state_next = bpa_pkg::S_SPLIT;
                else if (more_words || k_can_rise)
                    state_next = bpa_pkg::S_ALLOC_EV;
                else
                    state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_SPLIT:
                state_next = (k_reg > ord_reg) ? bpa_pkg::S_BIT_WR : bpa_pkg::S_FIN;
            bpa_pkg::S_REL_CHK:
                state_next = rel_ok ? bpa_pkg::S_REL_RD : bpa_pkg::S_DONE;
            bpa_pkg::S_REL_RD:
                state_next = k_can_rise ? bpa_pkg::S_REL_EV : bpa_pkg::S_BIT_WR;
            bpa_pkg::S_REL_EV:
                state_next = map_rdata[buddy_sel] ? bpa_pkg::S_REL_RD : bpa_pkg::S_FIN;
            bpa_pkg::S_FIN:
                state_next = bpa_pkg::S_DONE;
            bpa_pkg::S_DONE:
                state_next = out_free ? bpa_pkg::S_IDLE : bpa_pkg::S_DONE;
            default:
                state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // Datapath and bitmap requests
    always_comb
    begin
        ret_next        = ret_reg;
        ord_next        = ord_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        w_next          = w_reg;
        addr_next       = addr_reg;
        sel_next        = sel_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        rel_next        = rel_reg;
        ge_next         = ge_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_ord_next    = res_ord_reg;
        map_req         = '0;
        map_req.addr    = addr_reg;

        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    ord_next        = order;
                    k_next          = order;
                    w_next          = '0;
                    rel_next        = page - base_page_reg;
                    ge_next         = page >= base_page_reg;
                    res_status_next = bpa_pkg::STAT_INVALID;
                    res_page_next   = '0;
                    res_ord_next    = '0;
                    priority if (command == bpa_pkg::CMD_INIT)
                    begin
                        map_req.clr = 1'b1;
                        cur_next    = '0;
                        rem_next    = n_pages;
                    end
                    else if (command == bpa_pkg::CMD_ALLOC && order_ok)
                    begin
                        addr_next    = bpa_pkg::WORD_OFF[order];
                        map_req.rd   = 1'b1;
                        map_req.addr = addr_next;
                    end
                    else
                    begin
                    end
                end
            end
            bpa_pkg::S_CARVE:
            begin
                if (rem_reg == '0)
                begin
                    res_status_next = bpa_pkg::STAT_OK;
                    res_page_next   = base_page_reg;
                    res_ord_next    = '0;
                end
                else
                begin
                    addr_next    = bpa_pkg::WORD_OFF[carve_k]
                                   + bpa_pkg::ADDR_W'(carve_idx >> bpa_pkg::SEL_W);
                    sel_next     = carve_idx[bpa_pkg::SEL_W-1:0];
                    cur_next     = cur_reg + (bpa_pkg::NP_W'(1) << carve_k);
                    rem_next     = rem_reg - (bpa_pkg::NP_W'(1) << carve_k);
                    ret_next     = bpa_pkg::S_CARVE;
                    map_req.rd   = 1'b1;
                    map_req.addr = addr_next;
                end
            end
            bpa_pkg::S_BIT_WR:
            begin
                map_req.wr    = 1'b1;
                map_req.wdata = map_rdata | (bpa_pkg::WORD_BITS'(1) << sel_reg);
            end
            bpa_pkg::S_ALLOC_EV:
            begin
                priority if (word_found)
                begin
                    idx_next      = bpa_pkg::NP_W'({w_reg, first_sel});
                    map_req.wr    = 1'b1;
                    map_req.wdata = map_rdata & ~(bpa_pkg::WORD_BITS'(1) << first_sel);
                end
                else if (more_words)
                begin
                    w_next       = w_reg + bpa_pkg::ADDR_W'(1);
                    addr_next    = addr_reg + bpa_pkg::ADDR_W'(1);
                    map_req.rd   = 1'b1;
                    map_req.addr = addr_next;
                end
                else if (k_can_rise)
                begin
                    k_next       = k_reg + bpa_pkg::ORD_W'(1);
                    w_next       = '0;
                    addr_next    = bpa_pkg::WORD_OFF[k_next];
                    map_req.rd   = 1'b1;
                    map_req.addr = addr_next;
                end
                else
                begin
                    res_status_next = bpa_pkg::STAT_NOMEM;
                    res_page_next   = '0;
                    res_ord_next    = ord_reg;
                end
            end
            bpa_pkg::S_SPLIT:
            begin
                if (k_reg > ord_reg)
                begin
                    k_next       = k_reg - bpa_pkg::ORD_W'(1);
                    idx_next     = split_idx;
                    addr_next    = bpa_pkg::WORD_OFF[k_next]
                                   + bpa_pkg::ADDR_W'(split_tgt >> bpa_pkg::SEL_W);
                    sel_next     = split_tgt[bpa_pkg::SEL_W-1:0];
                    ret_next     = bpa_pkg::S_SPLIT;
                    map_req.rd   = 1'b1;
                    map_req.addr = addr_next;
                end
            end
            bpa_pkg::S_REL_CHK:
            begin
                k_next   = ord_reg;
                idx_next = bpa_pkg::NP_W'(rel_reg >> ord_reg);
            end
            bpa_pkg::S_REL_RD:
            begin
                addr_next    = bpa_pkg::WORD_OFF[k_reg]
                               + bpa_pkg::ADDR_W'(idx_reg >> bpa_pkg::SEL_W);
                sel_next     = idx_reg[bpa_pkg::SEL_W-1:0];
                ret_next     = bpa_pkg::S_FIN;
                map_req.rd   = 1'b1;
                map_req.addr = addr_next;
            end
            bpa_pkg::S_REL_EV:
            begin
                map_req.wr = 1'b1;
                if (map_rdata[buddy_sel])
                begin
                    // buddy free: take it out and climb one order
                    map_req.wdata = map_rdata & ~(bpa_pkg::WORD_BITS'(1) << buddy_sel);
                    idx_next      = idx_reg >> 1;
                    k_next        = k_reg + bpa_pkg::ORD_W'(1);
                end
                else
                begin
                    map_req.wdata = map_rdata | (bpa_pkg::WORD_BITS'(1) << sel_reg);
                end
            end
            bpa_pkg::S_FIN:
            begin
                res_status_next = bpa_pkg::STAT_OK;
                res_page_next   = fin_page;
                res_ord_next    = k_reg;
            end
            bpa_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::S_IDLE;
            ret_reg   <= bpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg        <= ord_next;
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        w_reg          <= w_next;
        addr_reg       <= addr_next;
        sel_reg        <= sel_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        rel_reg        <= rel_next;
        ge_reg         <= ge_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_ord_reg    <= res_ord_next;
    end

    // Output register: loaded from the sequencer, held until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == bpa_pkg::S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bpa_pkg::S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
            out_ord_reg    <= res_ord_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign block_page  = out_page_reg;
    assign block_order = out_ord_reg;

    // Checks
    a_map_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(map_req.rd && map_req.wr))
        else $error("bitmap read and write in the same cycle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bpa_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_nomem_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status == bpa_pkg::STAT_NOMEM) |-> (block_page == '0))
        else $error("no-memory result with a nonzero page");

    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpa_pkg::S_SPLIT) |-> (k_reg >= ord_reg))
        else $error("split went below the requested order");

endmodule

@@ sim/buddy_page_allocator_tb.sv @@
// Self-checking testbench for the buddy page allocator: random and directed commands,
// an internal free-bitmap predictor and an in-order scoreboard.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
module buddy_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [bpa_pkg::STAT_W-1:0] status;
        logic [bpa_pkg::PAGE_W-1:0] block_page;
        logic [bpa_pkg::ORD_W-1:0]  block_order;
    } alloc_result_t;

    // Predicts allocator results and holds them in transfer order
    class alloc_scoreboard;
        bit free_bits [bpa_pkg::ORDERS][bpa_pkg::TOTAL_PAGES];
        logic [bpa_pkg::PAGE_W-1:0] base;
        int unsigned region;
        alloc_result_t pending [$];
        int mismatches;

        function new();
            base = '0;
            region = 512;
            mismatches = 0;
            foreach (free_bits[k, i]) free_bits[k][i] = 0;
        endfunction

        function int unsigned carved();
            return (region < bpa_pkg::TOTAL_PAGES) ? region : bpa_pkg::TOTAL_PAGES;
        endfunction

        function bit free_at(int k, int idx);
            if (k >= bpa_pkg::ORDERS || idx >= (bpa_pkg::TOTAL_PAGES >> k) || idx < 0)
                return 0;
            return free_bits[k][idx];
        endfunction

        function void set_bit(int k, int idx, bit v);
            if (k < bpa_pkg::ORDERS && idx < (bpa_pkg::TOTAL_PAGES >> k))
                free_bits[k][idx] = v;
        endfunction

        function void carve_region();
            int unsigned cur;
            int unsigned rem;
            int k;
            foreach (free_bits[a, b]) free_bits[a][b] = 0;
            cur = 0;
            rem = carved();
            while (rem > 0)
            begin
                for (k = bpa_pkg::ORDERS - 1; k >= 0; k--)
                begin
                    if ((1 << k) <= rem && (cur & ((1 << k) - 1)) == 0)
                    begin
                        set_bit(k, cur >> k, 1);
                        cur += (1 << k);
                        rem -= (1 << k);
                        break;
                    end
                end
            end
        endfunction

        // Note an accepted command and queue its expected result
        function void note_command(logic [bpa_pkg::CMD_W-1:0] cmd,
                                   logic [bpa_pkg::ORD_W-1:0] ord,
                                   logic [bpa_pkg::PAGE_W-1:0] pg);
            alloc_result_t r;
            int k;
            int idx;
            bit found;
            longint unsigned rel;
            longint unsigned lim;
            longint unsigned size;
            r.status = bpa_pkg::STAT_INVALID;
            r.block_page = '0;
            r.block_order = '0;
            if (cmd == bpa_pkg::CMD_INIT)
            begin
                carve_region();
                r.status = bpa_pkg::STAT_OK;
                r.block_page = base;
            end
            else if (cmd == bpa_pkg::CMD_ALLOC && ord < bpa_pkg::ORDERS)
            begin
                r.status = bpa_pkg::STAT_NOMEM;
                r.block_order = ord;
                found = 0;
                for (k = ord; k < bpa_pkg::ORDERS && !found; k++)
                begin
                    for (idx = 0; idx < (bpa_pkg::TOTAL_PAGES >> k); idx++)
                        if (free_bits[k][idx]) break;
                    if (idx < (bpa_pkg::TOTAL_PAGES >> k))
                    begin
                        found = 1;
                        set_bit(k, idx, 0);
                        while (k > ord)
                        begin
                            k--;
                            idx = idx << 1;
                            set_bit(k, idx + 1, 1);
                        end
                        r.status = bpa_pkg::STAT_OK;
                        r.block_page = bpa_pkg::PAGE_W'(base + (idx << ord));
                    end
                end
            end
            else if (cmd == bpa_pkg::CMD_RELEASE && ord < bpa_pkg::ORDERS)
            begin
                size = 1 << ord;
                if (pg >= base)
                begin
                    rel = pg - base;
                    lim = carved();
                    if (rel < lim && size <= lim - rel && (rel & (size - 1)) == 0)
                    begin
                        k = ord;
                        idx = rel >> ord;
                        while (k + 1 < bpa_pkg::ORDERS && free_at(k, idx ^ 1))
                        begin
                            set_bit(k, idx ^ 1, 0);
                            idx = idx >> 1;
                            k++;
                        end
                        set_bit(k, idx, 1);
                        r.status = bpa_pkg::STAT_OK;
                        r.block_page = bpa_pkg::PAGE_W'(base + (idx << k));
                        r.block_order = bpa_pkg::ORD_W'(k);
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [bpa_pkg::STAT_W-1:0] st,
                                   logic [bpa_pkg::PAGE_W-1:0] bp,
                                   logic [bpa_pkg::ORD_W-1:0] bo);
            alloc_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d page %0d order %0d", st, bp, bo);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || bp !== e.block_page || bo !== e.block_order)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d", e.status,
                             e.block_page, e.block_order, st, bp, bo);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpa_pkg::PAGE_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [bpa_pkg::CMD_W-1:0] command;
    logic [bpa_pkg::ORD_W-1:0] order;
    logic [bpa_pkg::PAGE_W-1:0] page;
    logic out_valid;
    logic out_ready;
    logic [bpa_pkg::STAT_W-1:0] status;
    logic [bpa_pkg::PAGE_W-1:0] block_page;
    logic [bpa_pkg::ORD_W-1:0] block_order;

    alloc_scoreboard sb;
    int idle_pct_in;
    int idle_pct_out;
    int hold_cycles;
    int unsigned cycle_count;
    logic [bpa_pkg::PAGE_W-1:0] live_pages [$];
    logic [bpa_pkg::ORD_W-1:0] live_orders [$];

    buddy_page_allocator u_dut (.*);

    initial clk = 0;
    always #10 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check transfers, idle ready at random or hold off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(status, block_page, block_order);
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_pct_out);
        end
    end

    // Offer one command and wait for its transfer; track allocated blocks.
    // Valid drops only when the sender idles before the next command.
    task automatic send_cmd(logic [bpa_pkg::CMD_W-1:0] c, logic [bpa_pkg::ORD_W-1:0] o,
                            logic [bpa_pkg::PAGE_W-1:0] p);
        if ($urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct_in)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        order <= o;
        page <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_command(c, o, p);
        if (c == bpa_pkg::CMD_INIT)
        begin
            live_pages.delete();
            live_orders.delete();
        end
        else if (c == bpa_pkg::CMD_ALLOC && sb.pending[$].status == bpa_pkg::STAT_OK)
        begin
            live_pages.push_back(sb.pending[$].block_page);
            live_orders.push_back(o);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_cfg(logic [bpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [bpa_pkg::PAGE_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bpa_pkg::CFG_BASE_PAGE)
            sb.base = val;
        else
            sb.region = val[bpa_pkg::REGION_W-1:0];
        @(posedge clk);
    endtask

    // Random traffic: mostly alloc/release of live blocks, some noise
    task automatic random_phase(int n);
        int sel;
        int j;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 3)
                send_cmd(bpa_pkg::CMD_INIT, $urandom, $urandom);
            else if (sel < 50)
                send_cmd(bpa_pkg::CMD_ALLOC,
                         $urandom_range(bpa_pkg::ORDERS > 6 ? 6 : bpa_pkg::ORDERS - 1),
                         $urandom);
            else if (sel < 85 && live_pages.size() > 0)
            begin
                j = $urandom_range(live_pages.size() - 1);
                send_cmd(bpa_pkg::CMD_RELEASE, live_orders[j], live_pages[j]);
                live_pages.delete(j);
                live_orders.delete(j);
            end
            else if (sel < 92)
                send_cmd(bpa_pkg::CMD_ALLOC, $urandom, $urandom);
            else if (sel < 96)
                send_cmd(bpa_pkg::CMD_RELEASE, $urandom, sb.base + $urandom_range(600));
            else
                send_cmd($urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        command = '0;
        order = '0;
        page = '0;
        out_ready = 0;
        hold_cycles = 0;
        idle_pct_in = 35;
        idle_pct_out = 35;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: alloc before init, init, extremes, errors
        send_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        send_cmd(bpa_pkg::CMD_ALLOC, 9, 0);
        send_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        send_cmd(bpa_pkg::CMD_ALLOC, 15, '1);
        send_cmd(bpa_pkg::CMD_RELEASE, 0, 0);
        send_cmd(bpa_pkg::CMD_RELEASE, 9, 0);
        send_cmd(bpa_pkg::CMD_RELEASE, 9, 0);
        send_cmd(bpa_pkg::CMD_RELEASE, 1, 1);
        send_cmd(bpa_pkg::CMD_RELEASE, 0, 512);
        send_cmd(bpa_pkg::CMD_RELEASE, 15, 0);
        send_cmd(2'd3, 15, '1);
        send_cmd(bpa_pkg::CMD_ALLOC, 1, '1);
        send_cmd(bpa_pkg::CMD_ALLOC, 3, 0);
        send_cmd(bpa_pkg::CMD_RELEASE, 1, 2);
        drain();

        // Odd region and high base
        write_cfg(bpa_pkg::CFG_BASE_PAGE, 27'h7FFFE00);
        write_cfg(bpa_pkg::CFG_REGION_PAGES, 10'd1023);
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        send_cmd(bpa_pkg::CMD_ALLOC, 9, 0);
        send_cmd(bpa_pkg::CMD_RELEASE, 0, 27'h7FFFDFF);
        send_cmd(bpa_pkg::CMD_RELEASE, 9, 27'h7FFFE00);
        drain();
        write_cfg(bpa_pkg::CFG_REGION_PAGES, 10'd0);
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        send_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        send_cmd(bpa_pkg::CMD_RELEASE, 0, 27'h7FFFE00);
        drain();

        // Random phases over several settings
        write_cfg(bpa_pkg::CFG_BASE_PAGE, 27'd0);
        write_cfg(bpa_pkg::CFG_REGION_PAGES, 10'd512);
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        random_phase(400);
        drain();

        write_cfg(bpa_pkg::CFG_BASE_PAGE, {$urandom} & 27'h7FFFE00);
        write_cfg(bpa_pkg::CFG_REGION_PAGES, $urandom_range(1, 511));
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        // Receiver holds off while commands keep coming
        hold_cycles = 400;
        random_phase(300);
        drain();

        // No idling stretch
        idle_pct_in = 0;
        idle_pct_out = 0;
        write_cfg(bpa_pkg::CFG_REGION_PAGES, $urandom_range(100, 300));
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        random_phase(300);
        drain();

        idle_pct_in = 35;
        idle_pct_out = 35;
        write_cfg(bpa_pkg::CFG_BASE_PAGE, 27'h4000000);
        write_cfg(bpa_pkg::CFG_REGION_PAGES, 10'd512);
        send_cmd(bpa_pkg::CMD_INIT, 0, 0);
        random_phase(400);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/bpa_pkg.sv
hdl/bpa_map.sv
hdl/buddy_page_allocator.sv
sim/buddy_page_allocator_tb.sv
